// File: sv/crp_pkg.sv
// shared constant for the corey relative permeability block
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

	// width of the threshold register write data
	localparam int CFG_W = 16;

endpackage

`default_nettype wire

// File: sv/crp_if.sv
// stream interfaces for cells, results and threshold writes
`timescale 1ns / 1ps
`default_nettype none

interface crp_in_if #(parameter int FRAC_BITS = 16);
	logic                      valid;
	logic                      ready;
	logic signed [FRAC_BITS+1:0] saturation;
	logic                      last_cell;

	modport source(output valid, saturation, last_cell, input ready);
	modport sink(input valid, saturation, last_cell, output ready);
endinterface

interface crp_out_if #(parameter int FRAC_BITS = 16);
	logic                        valid;
	logic                        ready;
	logic [FRAC_BITS:0]          saturation_out;
	logic [FRAC_BITS:0]          oil_perm;
	logic signed [FRAC_BITS+1:0] oil_perm_deriv;
	logic [FRAC_BITS:0]          gas_perm;
	logic [FRAC_BITS:0]          gas_perm_deriv;
	logic                        last_out;

	modport source(output valid, saturation_out, oil_perm, oil_perm_deriv, gas_perm,
		gas_perm_deriv, last_out, input ready);
	modport sink(input valid, saturation_out, oil_perm, oil_perm_deriv, gas_perm,
		gas_perm_deriv, last_out, output ready);
endinterface

interface crp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [crp_pkg::CFG_W-1:0]  sat_threshold;

	modport source(output valid, sat_threshold, input ready);
	modport sink(input valid, sat_threshold, output ready);
endinterface

`default_nettype wire

// File: sv/crp_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module crp_div_pipe #(
	parameter int QW = 18,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem0,
	input  wire logic [QW-1:0] nbits,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nb_s  [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	generate
		for (genvar i = 0; i < QW; i++) begin : g_step
			logic [DW-1:0] rem_i;
			logic [DW-1:0] den_i;
			logic [QW-1:0] nb_i;
			logic [QW-1:0] quo_i;
			logic [DW:0]   trial;
			logic [DW:0]   diff;
			logic          ge;

			if (i == 0) begin : g_first
				assign rem_i = rem0;
				assign nb_i  = nbits;
				assign den_i = den;
				assign quo_i = '0;
			end else begin : g_next
				assign rem_i = rem_s[i-1];
				assign nb_i  = nb_s[i-1];
				assign den_i = den_s[i-1];
				assign quo_i = quo_s[i-1];
			end

			// bring in the next numerator bit and try a subtract
			always_comb begin
				trial = {rem_i, nb_i[QW-1]};
				diff  = trial - {1'b0, den_i};
				ge    = (trial >= {1'b0, den_i});
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
					nb_s[i]  <= nb_i << 1;
					den_s[i] <= den_i;
					quo_s[i] <= {quo_i[QW-2:0], ge};
				end
			end
		end
	endgenerate

	assign quo = quo_s[QW-1];

endmodule

`default_nettype wire

// File: sv/crp_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module crp_sqrt_pipe #(
	parameter int RW = 17
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*RW-1:0] arg,
	output logic      [RW-1:0]   root
);

	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] arg_s  [RW];

	generate
		for (genvar i = 0; i < RW; i++) begin : g_step
			logic [RW:0]     rem_i;
			logic [RW-1:0]   root_i;
			logic [2*RW-1:0] arg_i;
			logic [RW+2:0]   trial;
			logic [RW+2:0]   cand;
			logic [RW+2:0]   diff;
			logic            ge;

			if (i == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign arg_i  = arg;
			end else begin : g_next
				assign rem_i  = rem_s[i-1];
				assign root_i = root_s[i-1];
				assign arg_i  = arg_s[i-1];
			end

			// next bit pair in, test against 4*root+1
			always_comb begin
				trial = {rem_i, arg_i[2*RW-1:2*RW-2]};
				cand  = {1'b0, root_i, 2'b01};
				diff  = trial - cand;
				ge    = (trial >= cand);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i]  <= ge ? diff[RW:0] : trial[RW:0];
					root_s[i] <= {root_i[RW-2:0], ge};
					arg_s[i]  <= arg_i << 2;
				end
			end
		end
	endgenerate

	assign root = root_s[RW-1];

endmodule

`default_nettype wire

// File: sv/corey_relative_permeability.sv
// top level: corey relative permeability pipeline
`timescale 1ns / 1ps
`default_nettype none

// Takes one cell's gas saturation per beat and returns the clamped saturation, the oil and gas
// relative permeabilities and their derivatives, with the last-cell flag passed along. One cell
// enters every cycle unless the result side stalls; each result passes through the input
// register, the bit-per-stage pipelines in series: the (T-S)/T divider, the two square roots
// running side by side, and the derivative divider, and then the result register. Multiplies
// sit at the head of the second divider. A stall on the result side holds the whole pipeline;
// nothing is dropped or repeated. The threshold register resets to 0.85, a zero threshold acts
// as the smallest step, and it should be written only while the pipeline is empty.
module corey_relative_permeability #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crp_cfg_if.sink   cfg,
	crp_in_if.sink    cells,
	crp_out_if.source results
);

	localparam int F  = FRAC_BITS;
	localparam int DA = F + 2;
	localparam int DB = F + 1;
	localparam int DC = F + 1;
	localparam logic [F-1:0] THR_RESET = F'((17 * (64'd1 << F) + 64'd10) / 64'd20);
	localparam logic [F:0]   ONE_Q     = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic         last;
		logic [F:0]   sat_out;
		logic         oil_en;
		logic         div1_sat;
		logic         gas_en;
		logic         gas_top;
		logic [F-1:0] x;
		logic [F-1:0] t;
	} pa_t;

	typedef struct packed {
		pa_t          a;
		logic [F+1:0] theta;
	} pb_t;

	typedef struct packed {
		logic       last;
		logic [F:0] sat_out;
		logic       oil_en;
		logic       div2_sat;
		logic       t_dummy_free;
		logic [F:0] kro;
		logic [F:0] krg;
		logic [F:0] dkrg;
	} pc_t;

	logic adv;

	// threshold register
	logic [F-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= F'(cfg.sat_threshold);
		end
	end

	// global advance: the output register is free or being drained
	logic out_valid_q;

	assign adv         = !out_valid_q || results.ready;
	assign cells.ready = adv;

	// input beat register
	logic                v_s1;
	logic signed [F+1:0] sat_s1;
	logic                last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cells.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s1  <= cells.saturation;
			last_s1 <= cells.last_cell;
		end
	end

	// compare against the threshold and set up the theta division
	logic [F-1:0]        t_w;
	logic signed [F+2:0] s_x;
	logic signed [F+2:0] t_x;
	logic signed [F+2:0] d_x;
	logic [F+1:0]        diff;
	pa_t                 pa_n;

	always_comb begin
		t_w  = (thr_q == '0) ? F'(1) : thr_q;
		s_x  = {sat_s1[F+1], sat_s1};
		t_x  = {3'b000, t_w};
		d_x  = t_x - s_x;
		diff = d_x[F+1:0];

		pa_n.last     = last_s1;
		pa_n.oil_en   = (s_x <= t_x);
		pa_n.div1_sat = (diff >= {t_w, 2'b00});
		pa_n.gas_en   = !sat_s1[F+1] && (sat_s1 != '0);
		pa_n.gas_top  = (s_x >= t_x);
		pa_n.x        = pa_n.gas_top ? t_w : sat_s1[F-1:0];
		pa_n.t        = t_w;
		pa_n.sat_out  = pa_n.gas_en ? sat_s1[F:0] : '0;
	end

	// theta = (T - S) * ONE / T
	logic [F+1:0] theta_w;

	crp_div_pipe #(.QW(DA), .DW(F)) u_div_theta (
		.clk   (clk),
		.en    (adv),
		.rem0  (diff[F+1:2]),
		.nbits ({diff[1:0], {F{1'b0}}}),
		.den   (t_w),
		.quo   (theta_w)
	);

	// sideband alongside the theta divider
	pa_t          pa_s [DA];
	logic [DA-1:0] va_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= '0;
		end else if (adv) begin
			va_s <= {va_s[DA-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s[0] <= pa_n;
			for (int i = 1; i < DA; i++) begin
				pa_s[i] <= pa_s[i-1];
			end
		end
	end

	// square roots of theta and of the gas operand
	logic [F:0] r_oil;
	logic [F:0] r_gas;

	crp_sqrt_pipe #(.RW(F + 1)) u_sqrt_oil (
		.clk  (clk),
		.en   (adv),
		.arg  ({theta_w, {F{1'b0}}}),
		.root (r_oil)
	);

	crp_sqrt_pipe #(.RW(F + 1)) u_sqrt_gas (
		.clk  (clk),
		.en   (adv),
		.arg  ({2'b00, pa_s[DA-1].x, {F{1'b0}}}),
		.root (r_gas)
	);

	// sideband alongside the square roots
	pb_t           pb_s [DB];
	logic [DB-1:0] vb_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_s <= '0;
		end else if (adv) begin
			vb_s <= {vb_s[DB-2:0], va_s[DA-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s[0] <= {pa_s[DA-1], theta_w};
			for (int i = 1; i < DB; i++) begin
				pb_s[i] <= pb_s[i-1];
			end
		end
	end

	// powers, gas derivative and setup of the oil derivative division
	pb_t          bq;
	logic [2*F-1:0] prod_oil;
	logic [2*F-1:0] prod_gas;
	logic [F+2:0]   r3o;
	logic [F+2:0]   r3g;
	pc_t            pc_n;

	always_comb begin
		bq       = pb_s[DB-1];
		prod_oil = bq.theta[F-1:0] * r_oil[F-1:0];
		prod_gas = bq.a.x * r_gas[F-1:0];
		r3o      = (F+3)'({r_oil, 1'b0}) + (F+3)'(r_oil);
		r3g      = (F+3)'({r_gas, 1'b0}) + (F+3)'(r_gas);

		pc_n.last         = bq.a.last;
		pc_n.sat_out      = bq.a.sat_out;
		pc_n.oil_en       = bq.a.oil_en;
		pc_n.div2_sat     = bq.a.div1_sat || (r3o >= {1'b0, bq.a.t, 2'b00});
		pc_n.t_dummy_free = 1'b0;
		if (!bq.a.oil_en) begin
			pc_n.kro = '0;
		end else if (bq.a.div1_sat || (bq.theta[F+1:F] != 2'b00)) begin
			pc_n.kro = ONE_Q;
		end else begin
			pc_n.kro = {1'b0, prod_oil[2*F-1:F]};
		end
		pc_n.krg  = bq.a.gas_en ? {1'b0, prod_gas[2*F-1:F]} : '0;
		pc_n.dkrg = (bq.a.gas_en && !bq.a.gas_top) ? r3g[F+1:1] : '0;
	end

	// oil derivative magnitude = 3 * sqrt(theta) * ONE / (2 * T)
	logic [F:0] q2;

	crp_div_pipe #(.QW(DC), .DW(F + 1)) u_div_deriv (
		.clk   (clk),
		.en    (adv),
		.rem0  (r3o[F+1:1]),
		.nbits ({r3o[0], {F{1'b0}}}),
		.den   ({bq.a.t, 1'b0}),
		.quo   (q2)
	);

	// sideband alongside the derivative divider
	pc_t           pc_s [DC];
	logic [DC-1:0] vc_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_s <= '0;
		end else if (adv) begin
			vc_s <= {vc_s[DC-2:0], vb_s[DB-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s[0] <= pc_n;
			for (int i = 1; i < DC; i++) begin
				pc_s[i] <= pc_s[i-1];
			end
		end
	end

	// saturate and negate the oil derivative
	pc_t          cq;
	logic [F+1:0] mag;

	always_comb begin
		cq = pc_s[DC-1];
		if (!cq.oil_en) begin
			mag = '0;
		end else if (cq.div2_sat || cq.t_dummy_free) begin
			mag = {2'b10, {F{1'b0}}};
		end else begin
			mag = {1'b0, q2};
		end
	end

	// result register
	logic [F:0]          sat_out_q;
	logic [F:0]          kro_q;
	logic signed [F+1:0] dkro_q;
	logic [F:0]          krg_q;
	logic [F:0]          dkrg_q;
	logic                last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vc_s[DC-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_out_q <= cq.sat_out;
			kro_q     <= cq.kro;
			dkro_q    <= -mag;
			krg_q     <= cq.krg;
			dkrg_q    <= cq.dkrg;
			last_q    <= cq.last;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.saturation_out = sat_out_q;
	assign results.oil_perm       = kro_q;
	assign results.oil_perm_deriv = dkro_q;
	assign results.gas_perm       = krg_q;
	assign results.gas_perm_deriv = dkrg_q;
	assign results.last_out       = last_q;

	// a held result blocks the input side in the same cycle
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |-> !cells.ready)
		else $error("input accepted while result stalled");

	// a gas derivative only comes with a positive saturation
	a_gas_deriv_needs_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.gas_perm_deriv != '0)) |-> (results.saturation_out != '0))
		else $error("gas derivative without positive saturation");

endmodule

`default_nettype wire
